>>> sv/polling_target_table_with_aging_macros.svh
// Assertion macros for the polling target table.
// Used by the top level only; no other dependencies.
`ifndef POLLING_TARGET_TABLE_WITH_AGING_MACROS_SVH
`define POLLING_TARGET_TABLE_WITH_AGING_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PTTA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PTTA_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define PTTA_ASSERT(lbl, prop, msg)
`define PTTA_NEVER(lbl, cond, msg)
`endif
`endif

>>> sv/ptta_pkg.sv
// Package for the polling target table: entry type, codes and constants.
// No dependencies.
package ptta_pkg;
	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = IDX_W + 1;

	localparam logic REG_STALE = 1'b0;
	localparam logic REG_EVICT = 1'b1;

	localparam logic [2:0] ACT_TOUCH  = 3'd0;
	localparam logic [2:0] ACT_VERIFY = 3'd1;
	localparam logic [2:0] ACT_SWEEP  = 3'd2;
	localparam logic [2:0] ACT_READ   = 3'd3;
	localparam logic [2:0] ACT_RHITS  = 3'd4;
	localparam logic [2:0] ACT_CLEAR  = 3'd5;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_IGN    = 3'd1;
	localparam logic [2:0] ST_UPD    = 3'd2;
	localparam logic [2:0] ST_INS    = 3'd3;
	localparam logic [2:0] ST_FULL   = 3'd4;
	localparam logic [2:0] ST_NOTFND = 3'd5;

	localparam logic [7:0]  DEV_BLOCKED = 8'h2A;
	localparam logic [31:0] DELTA_MIN   = 32'd100;
	localparam logic [31:0] DELTA_MAX   = 32'd10000;
	localparam logic [15:0] HITS_MAX    = 16'hFFFF;

	typedef struct packed {
		logic [23:0] key;
		logic [31:0] stamp;
		logic [13:0] period;
		logic [15:0] hits;
		logic [7:0]  sources;
		logic        live;
		logic        conf;
	} ent_t;

	localparam int ENT_W = $bits(ent_t);
endpackage

>>> sv/ptta_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> sv/ptta_touch_upd.sv
// Touch update of one matched entry: period average, channel mask, hits, flags.
// Depends on ptta_pkg.
module ptta_touch_upd
	import ptta_pkg::*;
(
	input  ent_t        old_ent,
	input  logic [2:0]  channel,
	input  logic [31:0] time_now,
	output ent_t        new_ent
);
	logic [31:0] delta;
	logic [15:0] avg;

	always_comb begin
		delta = time_now - old_ent.stamp;
		avg = ({2'b0, old_ent.period} * 16'd3) + delta[15:0];
		new_ent = old_ent;
		if (old_ent.stamp != 32'd0 && time_now > old_ent.stamp &&
		    delta >= DELTA_MIN && delta <= DELTA_MAX) begin
			if (old_ent.period == 14'd0)
				new_ent.period = delta[13:0];
			else
				new_ent.period = avg[15:2];
		end
		new_ent.stamp = time_now;
		new_ent.sources = old_ent.sources | (8'd1 << channel);
		if (old_ent.hits != HITS_MAX)
			new_ent.hits = old_ent.hits + 16'd1;
		new_ent.live = 1'b1;
		new_ent.conf = 1'b1;
	end
endmodule

>>> sv/polling_target_table_with_aging.sv
// Each item walks the stored entries for its operation, then walks them again
// to count live and confirmed entries for the result.
// Throughput: one item at a time; the entry RAM's single read port sets the pace.
// A finished result waits in the output register while the next item is taken.
// Reset: arst_n clears fill level and control state, sets limits to defaults; entry RAM is not cleared.
`include "polling_target_table_with_aging_macros.svh"
module polling_target_table_with_aging
	import ptta_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// action[2:0], channel[5:3], key_device[13:6], key_sub_a[21:14],
	// key_sub_b[29:22], time_now[61:30], entry_slot[66:62], zero pad
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[2:0], slot_out[7:3], read_device[15:8], read_sub_a[23:16],
	// read_sub_b[31:24], read_period[45:32], read_hits[61:46],
	// read_sources[69:62], read_flags[71:70], stored_total[77:72],
	// live_total[83:78], confirmed_total[89:84], zero pad
	output logic [95:0] m_tdata,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_EV   = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]       state_q;
	logic             cnt_q;
	logic [CNT_W-1:0] idx_q, w_q, fill_q, live_q, conf_q;
	logic [31:0]      stale_q, evict_q;
	logic [2:0]       act_q, ch_q;
	logic [23:0]      key_q;
	logic [31:0]      now_q;
	logic [2:0]       status_q;
	logic [4:0]       slot_q;
	ent_t             rd_q;
	logic             m_valid_q;
	logic [95:0]      m_data_q;

	logic             we;
	logic [IDX_W-1:0] waddr, raddr;
	ent_t             wdata, rdata, upd_ent;
	logic [ENT_W-1:0] rdata_raw;
	logic [31:0]      elapsed;
	logic [23:0]      in_key;

	assign in_key = {s_tdata[13:6], s_tdata[21:14], s_tdata[29:22]};
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;
	assign rdata = ent_t'(rdata_raw);
	assign raddr = idx_q[IDX_W-1:0];
	assign elapsed = now_q - rdata.stamp;

	ptta_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata_raw)
	);

	ptta_touch_upd u_upd (
		.old_ent(rdata), .channel(ch_q), .time_now(now_q), .new_ent(upd_ent)
	);

	always_comb begin
		we = 1'b0;
		waddr = idx_q[IDX_W-1:0];
		wdata = rdata;
		if (state_q == S_EV && !cnt_q) begin
			case (act_q)
				ACT_TOUCH: begin
					we = (rdata.key == key_q);
					wdata = upd_ent;
				end
				ACT_VERIFY: begin
					we = (rdata.key == key_q);
					wdata.conf = 1'b1;
				end
				ACT_SWEEP: begin
					we = (elapsed <= evict_q);
					waddr = w_q[IDX_W-1:0];
					if (elapsed > stale_q)
						wdata.live = 1'b0;
				end
				ACT_RHITS: begin
					we = 1'b1;
					wdata.hits = 16'd0;
				end
				default: we = 1'b0;
			endcase
		end else if (state_q == S_RD && !cnt_q && idx_q >= fill_q &&
		             act_q == ACT_TOUCH && fill_q < CNT_W'(TABLE_DEPTH)) begin
			we = 1'b1;
			waddr = fill_q[IDX_W-1:0];
			wdata.key = key_q;
			wdata.stamp = now_q;
			wdata.period = 14'd0;
			wdata.sources = 8'd1 << ch_q;
			wdata.hits = 16'd1;
			wdata.live = 1'b1;
			wdata.conf = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= 1'b0;
			idx_q <= '0;
			w_q <= '0;
			fill_q <= '0;
			live_q <= '0;
			conf_q <= '0;
			stale_q <= 32'd60000;
			evict_q <= 32'd600000;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_EVICT)
					evict_q <= cfg_data;
				else
					stale_q <= cfg_data;
			end
			if (m_valid_q && m_tready && state_q != S_DONE)
				m_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						act_q <= s_tdata[2:0];
						ch_q <= s_tdata[5:3];
						key_q <= in_key;
						now_q <= s_tdata[61:30];
						status_q <= ST_OK;
						slot_q <= 5'd0;
						rd_q <= '0;
						cnt_q <= 1'b0;
						w_q <= '0;
						live_q <= '0;
						conf_q <= '0;
						idx_q <= '0;
						state_q <= S_RD;
						case (s_tdata[2:0])
							ACT_TOUCH: begin
								if (!(s_tdata[5:3] == 3'd2 || s_tdata[5:3] == 3'd3 ||
								      s_tdata[5:3] == 3'd5) || s_tdata[13:6] == DEV_BLOCKED) begin
									status_q <= ST_IGN;
									cnt_q <= 1'b1;
								end else if (in_key == 24'd0) begin
									idx_q <= fill_q;
								end
							end
							ACT_READ: begin
								slot_q <= s_tdata[66:62];
								if (CNT_W'(s_tdata[66:62]) < fill_q)
									idx_q <= CNT_W'(s_tdata[66:62]);
								else
									idx_q <= fill_q;
							end
							ACT_CLEAR: begin
								fill_q <= '0;
							end
							ACT_VERIFY, ACT_SWEEP, ACT_RHITS: begin
							end
							default: begin
								status_q <= ST_IGN;
								cnt_q <= 1'b1;
							end
						endcase
					end
				end
				S_RD: begin
					if (idx_q >= fill_q) begin
						if (cnt_q) begin
							state_q <= S_DONE;
						end else begin
							case (act_q)
								ACT_TOUCH: begin
									if (fill_q < CNT_W'(TABLE_DEPTH)) begin
										status_q <= ST_INS;
										slot_q <= fill_q[4:0];
										fill_q <= fill_q + 1'b1;
									end else begin
										status_q <= ST_FULL;
									end
								end
								ACT_VERIFY: status_q <= ST_NOTFND;
								ACT_READ:   status_q <= ST_NOTFND;
								ACT_SWEEP:  fill_q <= w_q;
								default:    status_q <= status_q;
							endcase
							cnt_q <= 1'b1;
							idx_q <= '0;
						end
					end else begin
						state_q <= S_EV;
					end
				end
				S_EV: begin
					state_q <= S_RD;
					idx_q <= idx_q + 1'b1;
					if (cnt_q) begin
						if (rdata.live) begin
							live_q <= live_q + 1'b1;
							if (rdata.conf)
								conf_q <= conf_q + 1'b1;
						end
					end else begin
						case (act_q)
							ACT_TOUCH, ACT_VERIFY: begin
								if (rdata.key == key_q) begin
									status_q <= (act_q == ACT_TOUCH) ? ST_UPD : ST_OK;
									slot_q <= idx_q[4:0];
									cnt_q <= 1'b1;
									idx_q <= '0;
								end
							end
							ACT_SWEEP: begin
								if (elapsed <= evict_q)
									w_q <= w_q + 1'b1;
							end
							ACT_READ: begin
								rd_q <= rdata;
								cnt_q <= 1'b1;
								idx_q <= '0;
							end
							default: cnt_q <= cnt_q;
						endcase
					end
				end
				S_DONE: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						m_data_q <= {6'd0, 6'(conf_q), 6'(live_q), 6'(fill_q),
						             rd_q.conf, rd_q.live, rd_q.sources, rd_q.hits,
						             rd_q.period, rd_q.key[7:0], rd_q.key[15:8],
						             rd_q.key[23:16], slot_q, status_q};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`PTTA_NEVER(a_fill_range, fill_q > CNT_W'(TABLE_DEPTH), "fill level beyond table depth")
	`PTTA_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "accepted while busy")
	`PTTA_ASSERT(a_out_held, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result lost")
endmodule

>>> test/tb.sv
// Self-checking testbench for polling_target_table_with_aging.
// Drives the item stream against a behavioral copy of the table and checks every result.
// Depends on ptta_pkg and the top level only.
module tb;
	import ptta_pkg::*;

	localparam logic [2:0] ACT_BAD6 = 3'd6;
	localparam logic [2:0] ACT_BAD7 = 3'd7;
	localparam int RANDOM_ITEMS = 800;
	localparam int CYCLE_LIMIT = 900000;
	localparam int DRAIN_CYCLES = 150;

	typedef struct {
		logic [2:0]  action;
		logic [2:0]  channel;
		logic [23:0] key;
		logic [31:0] now;
		logic [4:0]  slot;
		bit          typed;
		logic [2:0]  t_status;
		logic [5:0]  t_stored;
	} op_t;

	typedef struct {
		logic [2:0]  status;
		logic [4:0]  slot;
		logic [23:0] key;
		logic [13:0] period;
		logic [15:0] hits;
		logic [7:0]  sources;
		logic [1:0]  flags;
		logic [5:0]  stored;
		logic [5:0]  live;
		logic [5:0]  conf;
	} res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [71:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;

	polling_target_table_with_aging dut (.*);

	always #4 clk = ~clk;

	// table copy
	logic [31:0] lim_stale, lim_evict;
	ent_t tbl[TABLE_DEPTH];
	int unsigned fill;

	res_t result_q[$];
	int errs = 0;
	int n_acc = 0, n_got = 0, n_ins = 0, n_upd = 0, n_full = 0;
	int unsigned cycles = 0;
	int burst_left = 0;
	int hold_cycles = 0;
	bit hold_done = 1'b0;

	function automatic int find_entry(logic [23:0] key);
		for (int i = 0; i < fill; i++)
			if (tbl[i].key == key)
				return i;
		return TABLE_DEPTH;
	endfunction

	function automatic res_t table_step(op_t op);
		res_t r;
		int i, w;
		logic [31:0] d, el;
		r = '{default: '0};
		case (op.action)
			ACT_TOUCH: begin
				if (!(op.channel inside {3'd2, 3'd3, 3'd5}) || op.key[23:16] == DEV_BLOCKED)
					r.status = ST_IGN;
				else begin
					i = (op.key != 0) ? find_entry(op.key) : TABLE_DEPTH;
					if (i < TABLE_DEPTH) begin
						if (tbl[i].stamp > 0 && op.now > tbl[i].stamp) begin
							d = op.now - tbl[i].stamp;
							if (d >= DELTA_MIN && d <= DELTA_MAX)
								tbl[i].period = (tbl[i].period == 0) ? d[13:0] :
									14'((32'(tbl[i].period) * 3 + d) / 4);
						end
						tbl[i].stamp = op.now;
						tbl[i].sources[op.channel] = 1'b1;
						if (tbl[i].hits != HITS_MAX)
							tbl[i].hits++;
						tbl[i].live = 1'b1;
						tbl[i].conf = 1'b1;
						r.status = ST_UPD;
						r.slot = i[4:0];
						n_upd++;
					end else if (fill >= TABLE_DEPTH) begin
						r.status = ST_FULL;
						n_full++;
					end else begin
						tbl[fill] = '{key: op.key, stamp: op.now, period: '0,
							hits: 16'd1, sources: 8'(1 << op.channel), live: 1'b1, conf: 1'b1};
						r.status = ST_INS;
						r.slot = fill[4:0];
						fill++;
						n_ins++;
					end
				end
			end
			ACT_VERIFY: begin
				i = find_entry(op.key);
				if (i < TABLE_DEPTH) begin
					tbl[i].conf = 1'b1;
					r.slot = i[4:0];
				end else
					r.status = ST_NOTFND;
			end
			ACT_SWEEP: begin
				w = 0;
				for (i = 0; i < fill; i++) begin
					el = op.now - tbl[i].stamp;
					if (el > lim_stale)
						tbl[i].live = 1'b0;
					if (el <= lim_evict) begin
						tbl[w] = tbl[i];
						w++;
					end
				end
				fill = w;
			end
			ACT_READ: begin
				r.slot = op.slot;
				if (op.slot < fill) begin
					r.key = tbl[op.slot].key;
					r.period = tbl[op.slot].period;
					r.hits = tbl[op.slot].hits;
					r.sources = tbl[op.slot].sources;
					r.flags = {tbl[op.slot].conf, tbl[op.slot].live};
				end else
					r.status = ST_NOTFND;
			end
			ACT_RHITS:
				for (i = 0; i < fill; i++)
					tbl[i].hits = '0;
			ACT_CLEAR: fill = 0;
			default: r.status = ST_IGN;
		endcase
		for (i = 0; i < fill; i++)
			if (tbl[i].live) begin
				r.live++;
				if (tbl[i].conf)
					r.conf++;
			end
		r.stored = fill[5:0];
		return r;
	endfunction

	task automatic write_reg(logic idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_STALE)
			lim_stale = val;
		else
			lim_evict = val;
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (result_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_op(op_t op);
		res_t r;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tdata <= {5'd0, op.slot, op.now, op.key[7:0], op.key[15:8], op.key[23:16],
			op.channel, op.action};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		r = table_step(op);
		if (op.typed) begin
			r.status = op.t_status;
			r.stored = op.t_stored;
		end
		result_q.push_back(r);
		n_acc++;
	endtask

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			errs++;
		end
	endtask

	always @(posedge clk) begin
		res_t e;
		if (m_tvalid && m_tready) begin
			n_got++;
			if (result_q.size() == 0) begin
				$error("result with nothing expected");
				errs++;
			end else begin
				e = result_q.pop_front();
				check_field("status", e.status, m_tdata[2:0]);
				check_field("slot_out", e.slot, m_tdata[7:3]);
				check_field("read_device", e.key[23:16], m_tdata[15:8]);
				check_field("read_sub_a", e.key[15:8], m_tdata[23:16]);
				check_field("read_sub_b", e.key[7:0], m_tdata[31:24]);
				check_field("read_period", e.period, m_tdata[45:32]);
				check_field("read_hits", e.hits, m_tdata[61:46]);
				check_field("read_sources", e.sources, m_tdata[69:62]);
				check_field("read_flags", e.flags, m_tdata[71:70]);
				check_field("stored_total", e.stored, m_tdata[77:72]);
				check_field("live_total", e.live, m_tdata[83:78]);
				check_field("confirmed_total", e.conf, m_tdata[89:84]);
			end
		end
	end

	// receiver stall pattern with one long hold-off
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else if (!hold_done && n_got == 120) begin
			hold_done <= 1'b1;
			hold_cycles <= 600;
			m_tready <= 1'b0;
		end else if ((cycles / 512) % 3 == 0)
			m_tready <= 1'b1;
		else
			m_tready <= ($urandom_range(0, 3) != 0);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	op_t dir_tbl[$];
	logic [23:0] pool[40];
	logic [31:0] tnow;

	function automatic op_t mk(logic [2:0] a, logic [2:0] c, logic [23:0] k,
			logic [31:0] n, logic [4:0] s, bit ty, logic [2:0] st, logic [5:0] sz);
		op_t o;
		o = '{action: a, channel: c, key: k, now: n, slot: s, typed: ty,
			t_status: st, t_stored: sz};
		return o;
	endfunction

	function automatic op_t rand_op();
		op_t o;
		int p;
		o = mk(ACT_TOUCH, 3'd2, '0, '0, '0, 1'b0, ST_OK, '0);
		p = $urandom_range(0, 99);
		o.action = (p < 60) ? ACT_TOUCH : (p < 68) ? ACT_VERIFY : (p < 77) ? ACT_SWEEP :
			(p < 92) ? ACT_READ : (p < 95) ? ACT_RHITS : (p < 97) ? ACT_CLEAR :
			3'($urandom_range(6, 7));
		o.channel = ($urandom_range(0, 9) == 0) ? 3'($urandom) :
			(p % 3 == 0) ? 3'd2 : (p % 3 == 1) ? 3'd3 : 3'd5;
		o.key = ($urandom_range(0, 19) == 0) ? 24'($urandom) : pool[$urandom_range(0, 39)];
		o.slot = 5'($urandom);
		p = $urandom_range(0, 99);
		if (p < 80)
			tnow += $urandom_range(0, 3000);
		else if (p < 95)
			tnow += $urandom_range(50000, 700000);
		else if (p < 98)
			tnow = $urandom;
		o.now = tnow;
		return o;
	endfunction

	initial begin
		lim_stale = 32'd60000;
		lim_evict = 32'd600000;
		fill = 0;
		pool[0] = '0;
		pool[1] = {DEV_BLOCKED, 16'h1234};
		pool[2] = 24'hFFFFFF;
		for (int i = 3; i < 40; i++)
			pool[i] = 24'($urandom);
		dir_tbl = '{
			mk(ACT_READ, 3'd0, 24'h0, 32'd0, 5'd0, 1'b1, ST_NOTFND, 6'd0),
			mk(ACT_TOUCH, 3'd1, 24'h010203, 32'd500, 5'd0, 1'b1, ST_IGN, 6'd0),
			mk(ACT_TOUCH, 3'd2, 24'h2A0000, 32'd500, 5'd0, 1'b1, ST_IGN, 6'd0),
			mk(ACT_TOUCH, 3'd2, 24'h000000, 32'd1000, 5'd0, 1'b1, ST_INS, 6'd1),
			mk(ACT_TOUCH, 3'd3, 24'h000000, 32'd1000, 5'd0, 1'b1, ST_INS, 6'd2),
			mk(ACT_TOUCH, 3'd5, 24'hFFFFFF, 32'd2000, 5'd0, 1'b1, ST_INS, 6'd3),
			mk(ACT_TOUCH, 3'd5, 24'hFFFFFF, 32'd2050, 5'd0, 1'b1, ST_UPD, 6'd3),
			mk(ACT_TOUCH, 3'd2, 24'hFFFFFF, 32'd3050, 5'd0, 1'b1, ST_UPD, 6'd3),
			mk(ACT_TOUCH, 3'd3, 24'hFFFFFF, 32'd4050, 5'd0, 1'b0, ST_OK, 6'd0),
			mk(ACT_TOUCH, 3'd3, 24'hFFFFFF, 32'd14051, 5'd0, 1'b0, ST_OK, 6'd0),
			mk(ACT_TOUCH, 3'd7, 24'hFFFFFF, 32'd15000, 5'd0, 1'b1, ST_IGN, 6'd3),
			mk(ACT_VERIFY, 3'd0, 24'h000000, 32'd0, 5'd0, 1'b1, ST_OK, 6'd3),
			mk(ACT_VERIFY, 3'd0, 24'h123456, 32'd0, 5'd0, 1'b1, ST_NOTFND, 6'd3),
			mk(ACT_READ, 3'd0, 24'h0, 32'd0, 5'd2, 1'b0, ST_OK, 6'd0),
			mk(ACT_READ, 3'd0, 24'h0, 32'd0, 5'd31, 1'b1, ST_NOTFND, 6'd3),
			mk(ACT_RHITS, 3'd0, 24'h0, 32'd0, 5'd0, 1'b1, ST_OK, 6'd3),
			mk(ACT_READ, 3'd0, 24'h0, 32'd0, 5'd2, 1'b0, ST_OK, 6'd0),
			mk(ACT_BAD6, 3'd0, 24'h0, 32'd0, 5'd0, 1'b1, ST_IGN, 6'd3),
			mk(ACT_BAD7, 3'd0, 24'h0, 32'd0, 5'd0, 1'b1, ST_IGN, 6'd3),
			mk(ACT_SWEEP, 3'd0, 24'h0, 32'd80000, 5'd0, 1'b0, ST_OK, 6'd0),
			mk(ACT_SWEEP, 3'd0, 24'h0, 32'hFFFFFFFF, 5'd0, 1'b1, ST_OK, 6'd0),
			mk(ACT_TOUCH, 3'd5, 24'h112233, 32'hFFFFFFFF, 5'd0, 1'b1, ST_INS, 6'd1),
			mk(ACT_CLEAR, 3'd0, 24'h0, 32'd0, 5'd0, 1'b1, ST_OK, 6'd0)
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tbl[i])
			send_op(dir_tbl[i]);
		// fill past capacity
		for (int i = 0; i < 34; i++)
			send_op(mk(ACT_TOUCH, 3'd3, {8'h10, 8'(i), 8'hC3}, 32'd7000 + i, 5'd0,
				1'b0, ST_OK, 6'd0));
		send_op(mk(ACT_CLEAR, 3'd0, 24'h0, 32'd0, 5'd0, 1'b0, ST_OK, 6'd0));
		tnow = 32'd1000;
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			case (ph)
				0: begin write_reg(REG_STALE, 32'd60000); write_reg(REG_EVICT, 32'd600000); end
				1: begin write_reg(REG_STALE, 32'd0); write_reg(REG_EVICT, 32'd0); end
				2: begin write_reg(REG_STALE, '1); write_reg(REG_EVICT, '1); end
				3: begin write_reg(REG_STALE, 32'd2000); write_reg(REG_EVICT, 32'd20000); end
				default: begin
					write_reg(REG_STALE, $urandom_range(0, 200000));
					write_reg(REG_EVICT, $urandom_range(0, 2000000));
				end
			endcase
			for (int i = 0; i < RANDOM_ITEMS / 5; i++)
				send_op(rand_op());
		end
		drain();
		if (result_q.size() != 0) begin
			$error("%0d results never arrived", result_q.size());
			errs++;
		end
		$display("%0d items sent, %0d results checked: %0d inserts, %0d updates, %0d full",
			n_acc, n_got, n_ins, n_upd, n_full);
		$display("five limit settings including zero and all-ones; one long output stall");
		if (errs == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

>>> files.f
+incdir+sv
sv/ptta_pkg.sv
sv/ptta_ram.sv
sv/ptta_touch_upd.sv
sv/polling_target_table_with_aging.sv
test/tb.sv
